### hw/rtl/tdfc_pkg.sv
// ----------------------------------------------------------------------------
// tdfc_pkg
// Shared types, widths and helpers for the term and document frequency counter.
// ----------------------------------------------------------------------------
package tdfc_pkg;

  localparam int unsigned IdW          = 12;
  localparam int unsigned CntW         = 32;
  localparam int unsigned IdSpace      = 4096;  // ids the token_id field can carry
  localparam int unsigned VocabSizeDef = 4096;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic {
    KIND_COUNT = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  // Classified item as it travels from the front end to the back end
  typedef struct packed {
    kind_e          kind;
    logic           in_vocab;
    logic           closes;
    logic [IdW-1:0] id;
  } item_t;

  // One row of the count store
  typedef struct packed {
    logic [CntW-1:0] tag;
    logic [CntW-1:0] doc;
    logic [CntW-1:0] term;
  } entry_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : CntW'(v + 1'b1);
  endfunction

endpackage

### hw/rtl/tdfc_front.sv
// ----------------------------------------------------------------------------
// tdfc_front
// Takes items from the command port, tags them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module tdfc_front #(
  parameter int unsigned VOCAB_SIZE = tdfc_pkg::VocabSizeDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind_i,
  input  logic [tdfc_pkg::IdW-1:0] token_id_i,
  input  logic                     last_in_slice_i,
  input  logic                     init_done_i,
  input  logic                     pop_i,
  output logic                     head_valid_o,
  output tdfc_pkg::item_t          head_o
);
  import tdfc_pkg::*;

  localparam int unsigned VW = $clog2(VOCAB_SIZE + 1);
  localparam int unsigned CW = (VW > IdW) ? VW : IdW;
  localparam logic [CW-1:0] VocabLim = CW'(VOCAB_SIZE);

  item_t       ent_q [2];
  item_t       new_item;
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  assign busy         = (cnt_q == 2'd2) || !init_done_i;
  assign push         = start && !busy;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[rd_ptr_q];

  always_comb begin
    new_item.kind     = kind_e'(kind_i);
    new_item.in_vocab = (CW'(token_id_i) < VocabLim);
    new_item.closes   = last_in_slice_i && (kind_e'(kind_i) == KIND_COUNT);
    new_item.id       = token_id_i;
  end

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty queue");
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i && cnt_q == 2'd1) |=> busy)
    else $error("queue filled but not busy");
`endif

endmodule

### hw/rtl/tdfc_back.sv
// ----------------------------------------------------------------------------
// tdfc_back
// Count store, clearing pass after reset, and the read-modify-write of one
// item (registered store read, then update and write) with a registered result.
// ----------------------------------------------------------------------------
module tdfc_back #(
  parameter int unsigned VOCAB_SIZE = tdfc_pkg::VocabSizeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  tdfc_pkg::item_t           head_i,
  output logic                      pop_o,
  output logic                      init_done_o,
  output logic                      done_o,
  output logic [tdfc_pkg::IdW-1:0]  echo_id_o,
  output logic [tdfc_pkg::CntW-1:0] term_count_o,
  output logic [tdfc_pkg::CntW-1:0] doc_count_o,
  output logic [tdfc_pkg::CntW-1:0] slices_done_o
);
  import tdfc_pkg::*;

  localparam int unsigned Depth = (VOCAB_SIZE < IdSpace) ? VOCAB_SIZE : IdSpace;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic [CntW-1:0] slice_total_q, slice_total_d;
  item_t           item_q;
  entry_t          mem [Depth];
  entry_t          rd_q;
  entry_t          upd;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [CntW-1:0] tag;
  logic            is_count;

  logic            done_q;
  logic [IdW-1:0]  echo_q;
  logic [CntW-1:0] term_q, term_d;
  logic [CntW-1:0] doc_q, doc_d;

  assign init_done_o = (state_q != ST_CLEAR);
  assign pop_o       = (state_q == ST_IDLE) && head_valid_i;
  assign is_count    = (item_q.kind == KIND_COUNT);

  // Open slice carries slice_total + 1, sticking at the maximum
  assign tag = sat_inc(slice_total_q);

  always_comb begin
    upd.term = sat_inc(rd_q.term);
    if (rd_q.tag != tag) begin
      upd.tag = tag;
      upd.doc = sat_inc(rd_q.doc);
    end else begin
      upd.tag = rd_q.tag;
      upd.doc = rd_q.doc;
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    slice_total_d = slice_total_q;
    we            = 1'b0;
    waddr         = item_q.id[AW-1:0];
    wdata         = upd;
    term_d        = '0;
    doc_d         = '0;
    case (state_q)
      ST_CLEAR: begin
        we         = 1'b1;
        waddr      = clr_addr_q;
        wdata      = '0;
        clr_addr_d = AW'(clr_addr_q + 1'b1);
        if (clr_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        we = is_count && item_q.in_vocab;
        if (item_q.closes) begin
          slice_total_d = sat_inc(slice_total_q);
        end
        if (item_q.in_vocab) begin
          term_d = is_count ? upd.term : rd_q.term;
          doc_d  = is_count ? upd.doc  : rd_q.doc;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      slice_total_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      slice_total_q <= slice_total_d;
      done_q        <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
    if (state_q == ST_EXEC) begin
      echo_q <= item_q.id;
      term_q <= term_d;
      doc_q  <= doc_d;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop_o && head_i.in_vocab) begin
      rd_q <= mem[head_i.id[AW-1:0]];
    end
  end

  assign done_o        = done_q;
  assign echo_id_o     = echo_q;
  assign term_count_o  = term_q;
  assign doc_count_o   = doc_q;
  assign slices_done_o = slice_total_q;

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC))
    else $error("result strobe without execution");
  a_slices_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_done_o |=> slice_total_q >= $past(slice_total_q))
    else $error("slice total went backwards");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && item_q.kind == KIND_COUNT && item_q.in_vocab)
      |-> (term_q != '0 && doc_q != '0))
    else $error("counted id reports zero");
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done_o |-> !done_q)
    else $error("result during clearing pass");
`endif

endmodule

### hw/rtl/term_doc_frequency_counter_core.sv
// ----------------------------------------------------------------------------
// term_doc_frequency_counter_core
// Per-id term and document frequency counter with saturating counts.
// ----------------------------------------------------------------------------
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+----------------
//  command   | kind_i, token_id_i, last_in_slice_i           | start / busy
//  result    | echo_id_o, term_count_o, doc_count_o,         | done_o strobe,
//            | slices_done_o                                 | one cycle
//
//  Back end handles one item at a time (store read, then update and write),
//  taking no new item before it is done with the last. An accepted item goes
//  through the queue, the registered store read and ST_EXEC to a registered
//  result. After reset a clearing pass zeroes the min(VOCAB_SIZE, 4096) store
//  rows; busy is high throughout. A two-entry queue lets commands be taken
//  while the back end works; busy rises when it is full. Results stay on the
//  outputs until the next; treat each as valid only in its done_o cycle.
// ----------------------------------------------------------------------------
module term_doc_frequency_counter_core #(
  parameter int unsigned VOCAB_SIZE = tdfc_pkg::VocabSizeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind_i,
  input  logic [tdfc_pkg::IdW-1:0]  token_id_i,
  input  logic                      last_in_slice_i,
  output logic                      done_o,
  output logic [tdfc_pkg::IdW-1:0]  echo_id_o,
  output logic [tdfc_pkg::CntW-1:0] term_count_o,
  output logic [tdfc_pkg::CntW-1:0] doc_count_o,
  output logic [tdfc_pkg::CntW-1:0] slices_done_o
);
  import tdfc_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;
  logic  init_done;

  tdfc_front #(
    .VOCAB_SIZE (VOCAB_SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .token_id_i      (token_id_i),
    .last_in_slice_i (last_in_slice_i),
    .init_done_i     (init_done),
    .pop_i           (pop),
    .head_valid_o    (head_valid),
    .head_o          (head)
  );

  tdfc_back #(
    .VOCAB_SIZE (VOCAB_SIZE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .init_done_o   (init_done),
    .done_o        (done_o),
    .echo_id_o     (echo_id_o),
    .term_count_o  (term_count_o),
    .doc_count_o   (doc_count_o),
    .slices_done_o (slices_done_o)
  );

endmodule

### test/term_doc_frequency_counter_core_tb.sv
// ----------------------------------------------------------------------------
// term_doc_frequency_counter_core_tb
// Self-checking bench for the term and document frequency counter. A directed
// table covers empty reads, repeat sightings within a slice, slice closes on
// count items and ignored closes on reads. Then comes a random stream biased
// towards a few hot ids, sent under several sender idle patterns. Every result
// is checked field by field against its table row or an in-bench store model.
// ----------------------------------------------------------------------------
module term_doc_frequency_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdfc_pkg::*;

  localparam int unsigned Vocab        = VocabSizeDef;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned PhaseItems   = 430;
  localparam int unsigned NumDirected  = 24;
  localparam int unsigned MaxReports   = 10;

  typedef struct {
    logic [IdW-1:0]  id;
    logic [CntW-1:0] term;
    logic [CntW-1:0] doc;
    logic [CntW-1:0] slices;
  } counts_t;

  typedef struct {
    kind_e           kind;
    logic [IdW-1:0]  id;
    logic            closes;
    bit              typed;   // expected counts given in the row
    logic [CntW-1:0] term;
    logic [CntW-1:0] doc;
    logic [CntW-1:0] slices;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic            kind_i;
  logic [IdW-1:0]  token_id_i;
  logic            last_in_slice_i;
  logic            done_o;
  logic [IdW-1:0]  echo_id_o;
  logic [CntW-1:0] term_count_o;
  logic [CntW-1:0] doc_count_o;
  logic [CntW-1:0] slices_done_o;

  // model of the count store
  logic [CntW-1:0] term_tally [Vocab];
  logic [CntW-1:0] doc_tally  [Vocab];
  logic [CntW-1:0] seen_tag   [Vocab];
  logic [CntW-1:0] slices_closed;

  counts_t         pending_counts [$];
  stim_row_t       directed_rows  [NumDirected];
  logic [IdW-1:0]  hot_ids        [8];
  int unsigned     phase_idle     [4];

  logic            busy_seen;
  int unsigned     mismatches;
  int unsigned     cycle_count;

  term_doc_frequency_counter_core #(
    .VOCAB_SIZE(Vocab)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .token_id_i     (token_id_i),
    .last_in_slice_i(last_in_slice_i),
    .done_o         (done_o),
    .echo_id_o      (echo_id_o),
    .term_count_o   (term_count_o),
    .doc_count_o    (doc_count_o),
    .slices_done_o  (slices_done_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  // Applies one transfer to the store model and returns the counts it reports
  function automatic counts_t tally_token(input kind_e kind, input logic [IdW-1:0] id,
                                          input logic closes);
    counts_t         res;
    logic [CntW-1:0] open_tag;
    bit              in_vocab;
    in_vocab = (id < Vocab);
    if (kind == KIND_COUNT) begin
      if (in_vocab) begin
        open_tag       = bump(slices_closed);
        term_tally[id] = bump(term_tally[id]);
        if (seen_tag[id] != open_tag) begin
          seen_tag[id]  = open_tag;
          doc_tally[id] = bump(doc_tally[id]);
        end
      end
      if (closes)
        slices_closed = bump(slices_closed);
    end
    res.id     = id;
    res.term   = in_vocab ? term_tally[id] : '0;
    res.doc    = in_vocab ? doc_tally[id] : '0;
    res.slices = slices_closed;
    return res;
  endfunction

  // Drives one command after an optional idle gap and waits for its transfer
  task automatic push_item(input kind_e kind, input logic [IdW-1:0] id, input logic closes,
                           input int unsigned idle_pct, input bit typed,
                           input counts_t typed_counts);
    counts_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    kind_i          <= kind;
    token_id_i      <= id;
    last_in_slice_i <= closes;
    do @(posedge clk_i); while (busy_seen !== 1'b0);
    predicted = tally_token(kind, id, closes);
    pending_counts.insert(pending_counts.size(), typed ? typed_counts : predicted);
  endtask

  // Results hold from one rising edge to the next, so check them mid-cycle
  always @(negedge clk_i) begin
    counts_t want;
    busy_seen <= busy;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("[%0t] unexpected result: id %h term %0d doc %0d slices %0d", $realtime,
                   echo_id_o, term_count_o, doc_count_o, slices_done_o);
      end else begin
        want = pending_counts.pop_front();
        if (echo_id_o !== want.id || term_count_o !== want.term ||
            doc_count_o !== want.doc || slices_done_o !== want.slices) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("[%0t] mismatch: id %h/%h term %0d/%0d doc %0d/%0d slices %0d/%0d (exp/act)",
                     $realtime, want.id, echo_id_o, want.term, term_count_o,
                     want.doc, doc_count_o, want.slices, slices_done_o);
        end
      end
    end
  end

  initial begin
    counts_t     typed_counts;
    kind_e       kind;
    logic [IdW-1:0] id;
    logic        closes;

    rst_ni          = 1'b0;
    start           = 1'b0;
    kind_i          = KIND_COUNT;
    token_id_i      = '0;
    last_in_slice_i = 1'b0;
    busy_seen       = 1'b1;
    mismatches      = 0;
    cycle_count     = 0;

    for (int i = 0; i < Vocab; i++) begin
      term_tally[i] = '0;
      doc_tally[i]  = '0;
      seen_tag[i]   = '0;
    end
    slices_closed = '0;

    // kind, id, closes, typed, term, doc, slices
    directed_rows = '{
      '{KIND_READ,  12'h000, 1'b0, 1'b1, 0, 0, 0},
      '{KIND_READ,  12'hFFF, 1'b1, 1'b1, 0, 0, 0},   // close ignored on reads
      '{KIND_COUNT, 12'h000, 1'b0, 1'b1, 1, 1, 0},
      '{KIND_COUNT, 12'h000, 1'b0, 1'b1, 2, 1, 0},   // same slice, doc unchanged
      '{KIND_COUNT, 12'hFFF, 1'b1, 1'b1, 1, 1, 1},
      '{KIND_COUNT, 12'h000, 1'b0, 1'b1, 3, 2, 1},
      '{KIND_READ,  12'h000, 1'b1, 1'b1, 3, 2, 1},
      '{KIND_COUNT, 12'h000, 1'b1, 1'b1, 4, 2, 2},
      '{KIND_COUNT, 12'h000, 1'b1, 1'b1, 5, 3, 3},   // one-token slice
      '{KIND_COUNT, 12'hFFF, 1'b0, 1'b1, 2, 2, 3},
      '{KIND_READ,  12'hFFF, 1'b0, 1'b1, 2, 2, 3},
      '{KIND_COUNT, 12'h800, 1'b1, 1'b1, 1, 1, 4},
      '{KIND_COUNT, 12'h7FF, 1'b0, 1'b1, 1, 1, 4},
      '{KIND_COUNT, 12'hAAA, 1'b0, 1'b1, 1, 1, 4},
      '{KIND_COUNT, 12'h555, 1'b0, 1'b1, 1, 1, 4},
      '{KIND_COUNT, 12'hAAA, 1'b0, 1'b1, 2, 1, 4},
      '{KIND_COUNT, 12'h555, 1'b1, 1'b1, 2, 1, 5},
      '{KIND_READ,  12'h800, 1'b0, 1'b1, 1, 1, 5},
      '{KIND_COUNT, 12'h800, 1'b0, 1'b1, 2, 2, 5},
      '{KIND_COUNT, 12'h800, 1'b0, 1'b1, 3, 2, 5},
      '{KIND_COUNT, 12'h800, 1'b1, 1'b1, 4, 2, 6},
      '{KIND_READ,  12'h7FF, 1'b1, 1'b1, 1, 1, 6},
      '{KIND_COUNT, 12'h000, 1'b0, 1'b0, 0, 0, 0},
      '{KIND_COUNT, 12'hFFF, 1'b1, 1'b0, 0, 0, 0}
    };
    hot_ids    = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'h123, 12'hABC, 12'h007, 12'hFFE};
    phase_idle = '{0, 73, 0, 38};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // back to back, so repeat ids follow straight after their own update
    foreach (directed_rows[r]) begin
      typed_counts = '{directed_rows[r].id, directed_rows[r].term,
                       directed_rows[r].doc, directed_rows[r].slices};
      push_item(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].closes,
                0, directed_rows[r].typed, typed_counts);
    end

    typed_counts = '{'0, '0, '0, '0};
    foreach (phase_idle[p]) begin
      for (int n = 0; n < PhaseItems; n++) begin
        kind = ($urandom_range(3) == 0) ? KIND_READ : KIND_COUNT;
        if ($urandom_range(9) < 6)
          id = hot_ids[$urandom_range(7)];
        else
          id = IdW'($urandom_range(IdSpace - 1));
        // slices of a few tokens; the flag is noise on reads
        closes = (kind == KIND_READ) ? 1'($urandom_range(1)) : ($urandom_range(7) == 0);
        push_item(kind, id, closes, phase_idle[p], 1'b0, typed_counts);
      end
    end
    start <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hw/rtl/tdfc_pkg.sv
hw/rtl/tdfc_front.sv
hw/rtl/tdfc_back.sv
hw/rtl/term_doc_frequency_counter_core.sv
test/term_doc_frequency_counter_core_tb.sv
